// File: hdl/pfsc_pkg.sv
// package for the pcm/float32 sample converter
// types, format codes and the conversion functions; no dependencies
package pfsc_pkg;

  typedef enum logic [2:0] {
    FMT_U8      = 3'd0,
    FMT_S16     = 3'd1,
    FMT_S24     = 3'd2,
    FMT_S24IN32 = 3'd3,
    FMT_S32     = 3'd4,
    FMT_F32     = 3'd5,
    FMT_F64     = 3'd6,
    FMT_UNKNOWN = 3'd7
  } fmt_t;

  typedef enum logic {
    DIR_TO_FLOAT   = 1'b0,
    DIR_FROM_FLOAT = 1'b1
  } dir_t;

  typedef enum logic {
    CFG_DIRECTION = 1'b0,
    CFG_FORMAT    = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 3;

  typedef struct packed {
    logic [63:0] sample_in;
    logic        last_in;
  } sample_req_t;

  typedef struct packed {
    logic [63:0] sample_out;
    logic        last_out;
  } sample_rsp_t;

  localparam logic [31:0] F32_ONE   = 32'h3F80_0000;
  localparam logic [10:0] F64_EXP_BIAS_DIFF = 11'd896;

  // leading zero count, 32 when v is zero
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // signed integer (sign, magnitude) times 2^-k to float32, round to nearest even
  function automatic logic [31:0] int_to_f32(input logic sgn, input logic [31:0] mag,
                                             input logic [4:0] k);
    logic [5:0]  lz;
    logic [31:0] n;
    logic        rnd;
    logic [7:0]  ex;
    logic [30:0] body;
    lz   = lzc32(mag);
    n    = mag << lz;
    rnd  = n[7] & ((|n[6:0]) | n[8]);
    ex   = 8'(9'd158 - 9'(lz) - 9'(k));
    body = {ex, n[30:8]} + 31'(rnd);
    return (mag == 32'd0) ? 32'd0 : {sgn, body};
  endfunction

  // float64 bits to float32 bits, round to nearest even
  function automatic logic [31:0] f64_to_f32(input logic [63:0] b);
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] mant;
    logic signed [12:0] e32;
    logic [5:0]  sh;
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic        rnd;
    logic [7:0]  ef;
    logic [30:0] body;
    logic [31:0] res;
    sgn  = b[63];
    ex   = b[62:52];
    mant = b[51:0];
    e32  = $signed({2'b00, ex}) - $signed(13'(F64_EXP_BIAS_DIFF));
    x    = {11'd0, 1'b1, mant};
    if (e32 >= 13'sd1) begin
      sh = 6'd29;
      ef = e32[7:0];
    end else if (e32 <= -13'sd33) begin
      sh = 6'd63;
      ef = 8'd0;
    end else begin
      sh = 6'(13'sd30 - e32);
      ef = 8'd0;
    end
    q    = x >> sh;
    rem  = x & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 6'd1);
    rnd  = (rem > half) || ((rem == half) && q[0]);
    body = {ef, q[22:0]} + 31'(rnd);
    if (ex == 11'h7FF && mant != 52'd0) begin
      res = {sgn, 9'h1FF, mant[50:29]};
    end else if (ex == 11'h7FF || e32 >= 13'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else if (ex == 11'd0) begin
      res = {sgn, 31'd0};
    end else begin
      res = {sgn, body};
    end
    return res;
  endfunction

  // float32 bits to float64 bits, exact
  function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [5:0]  lz;
    logic [22:0] mn;
    logic [63:0] res;
    sgn = f[31];
    ex  = f[30:23];
    m   = f[22:0];
    lz  = lzc32({m, 9'd0});
    mn  = m << (lz + 6'd1);
    if (ex == 8'hFF) begin
      res = (m != 23'd0) ? {sgn, 11'h7FF, 1'b1, m[21:0], 29'd0} : {sgn, 11'h7FF, 52'd0};
    end else if (ex == 8'd0) begin
      res = (m == 23'd0) ? {sgn, 63'd0} : {sgn, F64_EXP_BIAS_DIFF - 11'(lz), mn, 29'd0};
    end else begin
      res = {sgn, 11'(ex) + F64_EXP_BIAS_DIFF, m, 29'd0};
    end
    return res;
  endfunction

  // clamp to [-1,1], multiply by the format scale in float32, truncate, saturate
  function automatic logic [31:0] quantize(input logic [31:0] f, input fmt_t fmt);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [23:0] sig;
    logic [4:0]  se;
    logic [5:0]  lead_lo;
    logic [30:0] hi;
    logic [47:0] p;
    logic [5:0]  lead;
    logic [5:0]  sh;
    logic [47:0] q;
    logic [47:0] rem;
    logic [47:0] half;
    logic        rnd;
    logic [24:0] r;
    logic signed [10:0] e2;
    logic [63:0] mag;
    logic [31:0] res;
    sgn = f[31];
    ex  = f[30:23];
    m   = f[22:0];
    if (f[30:0] > F32_ONE[30:0]) begin
      ex = F32_ONE[30:23];
      m  = 23'd0;
    end
    unique case (fmt)
      FMT_S16: begin
        sig = 24'd32767; se = 5'd0; lead_lo = 6'd37; hi = 31'd32767;
      end
      FMT_S32: begin
        sig = 24'd1; se = 5'd31; lead_lo = 6'd23; hi = 31'h7FFF_FFFF;
      end
      default: begin
        sig = 24'd8388607; se = 5'd0; lead_lo = 6'd45; hi = 31'd8388607;
      end
    endcase
    p    = {1'b1, m} * sig;
    lead = p[lead_lo + 6'd1] ? lead_lo + 6'd1 : lead_lo;
    sh   = lead - 6'd23;
    q    = p >> sh;
    rem  = p & ((48'd1 << sh) - 48'd1);
    half = (sh == 6'd0) ? 48'd0 : (48'd1 << (sh - 6'd1));
    rnd  = (sh != 6'd0) && ((rem > half) || ((rem == half) && q[0]));
    r    = q[24:0] + 25'(rnd);
    e2   = $signed({5'd0, sh}) + $signed({3'd0, ex}) + $signed({6'd0, se}) - 11'sd150;
    if (e2 >= 11'sd0) begin
      mag = (e2 > 11'sd39) ? 64'hFFFF_FFFF_FFFF : ({39'd0, r} << e2[5:0]);
    end else if (e2 <= -11'sd32) begin
      mag = 64'd0;
    end else begin
      mag = {39'd0, r} >> 6'(-e2);
    end
    if (!sgn) begin
      res = (mag >= {33'd0, hi}) ? {1'b0, hi} : mag[31:0];
    end else begin
      res = (mag >= {33'd0, hi} + 64'd1) ? ~{1'b0, hi} : 32'(64'd0 - mag);
    end
    // nan and subnormal inputs, checked on the unclamped bits
    if ((f[30:23] == 8'hFF && f[22:0] != 23'd0) || f[30:23] == 8'd0) begin
      res = 32'd0;
    end
    return res;
  endfunction

  // u8 from float: trunc(x*128 + 128.5) in float32, clamped to 0..255
  function automatic logic [7:0] quantize_u8(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [23:0] ms;
    logic signed [9:0] k;
    logic [63:0] y;
    logic        stk;
    logic [35:0] sf;
    logic [5:0]  lead;
    logic [5:0]  p;
    logic [35:0] q;
    logic [35:0] rem;
    logic [35:0] half;
    logic        rnd;
    logic [35:0] rr;
    logic [9:0]  iv;
    logic [7:0]  res;
    sgn = f[31];
    ex  = f[30:23];
    m   = f[22:0];
    if (f[30:0] > F32_ONE[30:0]) begin
      ex = F32_ONE[30:23];
      m  = 23'd0;
    end
    ms  = {ex != 8'd0, m};
    k   = $signed({2'd0, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd117;
    if (k >= 10'sd0) begin
      y   = {40'd0, ms} << k[5:0];
      stk = 1'b0;
    end else if (k <= -10'sd63) begin
      y   = 64'd0;
      stk = ms != 24'd0;
    end else begin
      y   = {40'd0, ms} >> 6'(-k);
      stk = |({40'd0, ms} & ((64'd1 << 6'(-k)) - 64'd1));
    end
    // 128.5 with 26 fraction bits
    if (!sgn) begin
      sf = 36'd257 << 25;
      sf = sf + y[35:0];
    end else begin
      sf = (36'd257 << 25) - y[35:0] - 36'(stk);
    end
    lead = 6'd25;
    for (int i = 26; i <= 34; i++) begin
      if (sf[i]) begin
        lead = 6'(i);
      end
    end
    p    = lead - 6'd23;
    q    = sf >> p;
    rem  = sf & ((36'd1 << p) - 36'd1);
    half = 36'd1 << (p - 6'd1);
    rnd  = (rem > half) || ((rem == half) && (stk || q[0]));
    rr   = (q + 36'(rnd)) << p;
    iv   = rr[35:26];
    res  = (iv > 10'd255) ? 8'd255 : iv[7:0];
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
      res = 8'd128;
    end
    return res;
  endfunction

endpackage

// File: hdl/pcm_float_sample_converter.sv
// pcm/float32 sample converter, top level
// input register, conversion logic, result register; uses pfsc_pkg
//
// a request passes the input register and then the result register; out_strobe marks the result
// throughput: one request per cycle, busy stays low; the receiver cannot stall
// the conversion logic between the two registers sets the clock rate
// reset (synchronous, rst_n low): direction to-float, format S16, no request in flight
module pcm_float_sample_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pfsc_pkg::sample_req_t         in_req,
  output logic                          out_strobe,
  output pfsc_pkg::sample_rsp_t         out_rsp,
  input  logic                          cfg_we,
  input  pfsc_pkg::cfg_idx_t            cfg_addr,
  input  logic [pfsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfsc_pkg::*;

  dir_t        dir_r;
  fmt_t        fmt_r;
  logic        in_vld_r;
  sample_req_t in_r;
  logic        out_vld_r;
  sample_rsp_t out_r;
  logic [63:0] conv_nxt;
  logic [31:0] q_val;
  logic [31:0] s_mag;
  logic        s_sgn;
  logic [4:0]  s_k;
  logic [31:0] s_val;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_TO_FLOAT;
      fmt_r <= FMT_S16;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DIRECTION: dir_r <= dir_t'(cfg_wdata[0]);
        CFG_FORMAT:    fmt_r <= fmt_t'(cfg_wdata);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_req;
    end
    if (in_vld_r) begin
      out_r.sample_out <= conv_nxt;
      out_r.last_out   <= in_r.last_in;
    end
  end

  // integer side of to-float: signed value and its scale exponent
  always_comb begin
    s_k = 5'd15;
    unique case (fmt_r)
      FMT_U8: begin
        s_val = {24'd0, in_r.sample_in[7:0]} - 32'd128;
        s_k   = 5'd7;
      end
      FMT_S16: begin
        s_val = {{16{in_r.sample_in[15]}}, in_r.sample_in[15:0]};
        s_k   = 5'd15;
      end
      FMT_S24, FMT_S24IN32: begin
        s_val = {{8{in_r.sample_in[23]}}, in_r.sample_in[23:0]};
        s_k   = 5'd23;
      end
      default: begin
        s_val = in_r.sample_in[31:0];
        s_k   = 5'd31;
      end
    endcase
    s_sgn = s_val[31];
    s_mag = s_sgn ? (32'd0 - s_val) : s_val;
  end

  always_comb begin
    q_val    = quantize(in_r.sample_in[31:0], fmt_r);
    conv_nxt = 64'd0;
    if (dir_r == DIR_TO_FLOAT) begin
      unique case (fmt_r)
        FMT_U8, FMT_S16, FMT_S24, FMT_S24IN32, FMT_S32:
          conv_nxt = {32'd0, int_to_f32(s_sgn, s_mag, s_k)};
        FMT_F32:     conv_nxt = {32'd0, in_r.sample_in[31:0]};
        FMT_F64:     conv_nxt = {32'd0, f64_to_f32(in_r.sample_in)};
        FMT_UNKNOWN: conv_nxt = 64'd0;
      endcase
    end else begin
      unique case (fmt_r)
        FMT_U8:      conv_nxt = {56'd0, quantize_u8(in_r.sample_in[31:0])};
        FMT_S16:     conv_nxt = {48'd0, q_val[15:0]};
        FMT_S24:     conv_nxt = {40'd0, q_val[23:0]};
        FMT_S24IN32, FMT_S32:
                     conv_nxt = {32'd0, q_val};
        FMT_F32:     conv_nxt = {32'd0, in_r.sample_in[31:0]};
        FMT_F64:     conv_nxt = f32_to_f64(in_r.sample_in[31:0]);
        FMT_UNKNOWN: conv_nxt = 64'd0;
      endcase
    end
  end

  assign out_strobe = out_vld_r;
  assign out_rsp    = out_r;

  // every accepted request gives exactly one strobe, after the input and result registers
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe) else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_strobe) else $error("result without request");

  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 (out_rsp.last_out == $past(in_req.last_in, 2)))
    else $error("last mark lost");

  a_to_float_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && dir_r == DIR_TO_FLOAT) |-> (out_rsp.sample_out[63:32] == 32'd0))
    else $error("upper bits set in to-float result");

endmodule

// File: tb/pcm_float_sample_converter_tb.sv
// testbench for pcm_float_sample_converter: directed and random requests in every
// direction/format setting, each result checked against a bit-exact predictor
// depends on pfsc_pkg and the pcm_float_sample_converter rtl
module pcm_float_sample_converter_tb;
  import pfsc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sample_req_t in_req;
  logic        out_strobe;
  sample_rsp_t out_rsp;
  logic        cfg_we;
  cfg_idx_t    cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dir_t        cur_dir;
  fmt_t        cur_fmt;
  sample_rsp_t pending_samples[$];
  int          fail_count;
  int          burst_left;
  bit          gaps_on;

  pcm_float_sample_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #400000;
    $display("pcm_float_sample_converter test failed");
    $finish;
  end

  // double bits to single bits, round to nearest even
  function automatic logic [31:0] narrow_to_single(input logic [63:0] b);
    logic        s;
    logic [10:0] ex;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] body;
    logic        rnd;
    int          e;
    int          sh;
    s  = b[63];
    ex = b[62:52];
    if (ex == 11'h7FF) begin
      return (b[51:0] != 52'd0) ? {s, 9'h1FF, b[50:29]} : {s, 8'hFF, 23'd0};
    end
    if (ex == 11'd0) begin
      return {s, 31'd0};
    end
    e = int'(ex) - 1023;
    if (e > 127) begin
      return {s, 8'hFF, 23'd0};
    end
    sig = {11'd0, 1'b1, b[51:0]};
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) begin
      return {s, 31'd0};
    end
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    rnd  = (rem > half) || ((rem == half) && q[0]);
    if (e >= -126) begin
      body = (32'(e + 127) << 23) + {9'd0, q[22:0]} + 32'(rnd);
    end else begin
      body = q[31:0] + 32'(rnd);
    end
    if (body >= 32'h7F80_0000) begin
      body = 32'h7F80_0000;
    end
    return {s, body[30:0]};
  endfunction

  // single bits to double bits, exact; nan gets the quiet bit
  function automatic logic [63:0] widen_to_double(input logic [31:0] f);
    logic        s;
    logic [7:0]  ex;
    logic [23:0] m;
    int          shifts;
    s  = f[31];
    ex = f[30:23];
    m  = {1'b0, f[22:0]};
    if (ex == 8'hFF) begin
      return (m != 24'd0) ? {s, 11'h7FF, 1'b1, m[21:0], 29'd0} : {s, 11'h7FF, 52'd0};
    end
    if (ex == 8'd0) begin
      if (m == 24'd0) begin
        return {s, 63'd0};
      end
      shifts = 0;
      while (!m[23]) begin
        m = m << 1;
        shifts++;
      end
      return {s, 11'(897 - shifts), m[22:0], 29'd0};
    end
    return {s, 11'(int'(ex) + 896), m[22:0], 29'd0};
  endfunction

  function automatic real round_single(input real r);
    return $bitstoreal(widen_to_double(narrow_to_single($realtobits(r))));
  endfunction

  function automatic bit single_is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  // integer pcm scaled by 2^-k; the product stays exact in double
  function automatic logic [31:0] pcm_to_single(input longint v, input int k);
    return narrow_to_single($realtobits(real'(v) / (2.0 ** k)));
  endfunction

  function automatic real clamp_unit(input logic [31:0] f);
    real x;
    x = $bitstoreal(widen_to_double(f));
    if (x > 1.0) x = 1.0;
    if (x < -1.0) x = -1.0;
    return x;
  endfunction

  // clamp, scale in single precision, truncate toward zero, saturate
  function automatic longint quantize_pcm(input logic [31:0] f, input real scale,
                                          input longint lo, input longint hi);
    real v;
    if (single_is_nan(f)) begin
      return 0;
    end
    v = round_single(clamp_unit(f) * scale);
    if (v >= real'(hi)) return hi;
    if (v <= real'(lo)) return lo;
    return longint'($rtoi(v));
  endfunction

  function automatic longint scale_to_u8(input logic [31:0] f);
    real    v;
    longint q;
    if (single_is_nan(f)) begin
      return 128;
    end
    v = round_single(clamp_unit(f) * 128.0 + 128.5);
    q = longint'($rtoi(v));
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q;
  endfunction

  function automatic logic [63:0] convert_sample(input dir_t d, input fmt_t fm,
                                                 input logic [63:0] s);
    logic [31:0] f;
    f = s[31:0];
    if (d == DIR_TO_FLOAT) begin
      case (fm)
        FMT_U8:      return {32'd0, pcm_to_single(longint'(s[7:0]) - 128, 7)};
        FMT_S16:     return {32'd0, pcm_to_single(longint'($signed(s[15:0])), 15)};
        FMT_S24,
        FMT_S24IN32: return {32'd0, pcm_to_single(longint'($signed(s[23:0])), 23)};
        FMT_S32:     return {32'd0, pcm_to_single(longint'($signed(s[31:0])), 31)};
        FMT_F32:     return {32'd0, f};
        FMT_F64:     return {32'd0, narrow_to_single(s)};
        default:     return 64'd0;
      endcase
    end
    case (fm)
      FMT_U8:      return 64'(scale_to_u8(f));
      FMT_S16:     return {48'd0, 16'(quantize_pcm(f, 32767.0, -32768, 32767))};
      FMT_S24:     return {40'd0, 24'(quantize_pcm(f, 8388607.0, -8388608, 8388607))};
      FMT_S24IN32: return {32'd0, 32'(quantize_pcm(f, 8388607.0, -8388608, 8388607))};
      FMT_S32:     return {32'd0, 32'(quantize_pcm(f, 2147483648.0, -64'sd2147483648,
                                                  2147483647))};
      FMT_F32:     return {32'd0, f};
      FMT_F64:     return widen_to_double(f);
      default:     return 64'd0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result %h", out_rsp.sample_out);
        fail_count++;
      end else begin
        sample_rsp_t want;
        want = pending_samples.pop_front();
        if (out_rsp.sample_out !== want.sample_out) begin
          $error("sample_out expected %h actual %h", want.sample_out, out_rsp.sample_out);
          fail_count++;
        end
        if (out_rsp.last_out !== want.last_out) begin
          $error("last_out expected %b actual %b", want.last_out, out_rsp.last_out);
          fail_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic [63:0] d, input logic l);
    sample_rsp_t want;
    start  <= 1'b1;
    in_req <= '{sample_in: d, last_in: l};
    @(posedge clk);
    while (busy) @(posedge clk);
    want.sample_out = convert_sample(cur_dir, cur_fmt, d);
    want.last_out   = l;
    pending_samples.push_back(want);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pause until every result is back, plus the pipeline depth
  task automatic drain;
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // raw register values; only the low bit of the direction value is kept
  task automatic configure(input logic [2:0] dv, input logic [2:0] fv);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DIRECTION;
    cfg_wdata <= dv;
    @(posedge clk);
    cfg_addr  <= CFG_FORMAT;
    cfg_wdata <= fv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_dir = dir_t'(dv[0]);
    cur_fmt = fmt_t'(fv);
  endtask

  function automatic logic [63:0] random_sample(input dir_t d, input fmt_t fm);
    logic [63:0] s;
    int          pick;
    s    = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    if (d == DIR_TO_FLOAT) begin
      if (fm == FMT_F64 && pick < 12) begin
        s[62:52] = 11'($urandom_range(860, 1160));
        if (pick == 0) s[62:52] = 11'h7FF;
        if (pick == 1) s[62:52] = 11'd0;
        if (pick == 2) s[28:0] = 29'h1000_0000;
        if (pick == 3) s[51:0] = 52'd0;
      end else if (pick == 0) begin
        s[31:0] = 32'h8000_0000 >> (8 * $urandom_range(0, 3));
      end
    end else if (pick < 13) begin
      s[30:23] = 8'($urandom_range(100, 128));
      if (pick == 0) s[30:23] = 8'hFF;
      if (pick == 1) s[30:23] = 8'd0;
      if (pick == 2) s[30:0] = F32_ONE[30:0];
    end
    return s;
  endfunction

  task automatic send_with_gaps(input logic [63:0] d, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) hold_off($urandom_range(0, 6));
    end
    burst_left--;
    send_sample(d, l);
  endtask

  task automatic test_reset_state;
    send_sample(64'h8000, 1'b0);
    send_sample(64'h7FFF, 1'b1);
    send_sample(64'hFFFF_FFFF_FFFF_0001, 1'b0);
  endtask

  task automatic test_to_float_edges;
    configure(3'b110, FMT_U8);
    send_sample(64'h00, 1'b0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    configure(3'(DIR_TO_FLOAT), FMT_S24IN32);
    send_sample(64'hFFFF_FFFF_0080_0000, 1'b0);
    send_sample(64'h0000_0000_FF7F_FFFF, 1'b0);
    configure(3'(DIR_TO_FLOAT), FMT_S32);
    send_sample(64'h8000_0000, 1'b0);
    send_sample(64'h7FFF_FFFF, 1'b0);
    configure(3'(DIR_TO_FLOAT), FMT_F64);
    send_sample(64'hFFF8_0000_2000_0001, 1'b0);
    send_sample(64'h47EF_FFFF_F000_0000, 1'b0);
    send_sample(64'hC7EF_FFFF_E000_0000, 1'b0);
    send_sample(64'h3690_0000_0000_0001, 1'b0);
    send_sample(64'h8000_0000_0000_0000, 1'b0);
  endtask

  task automatic test_from_float_edges;
    configure(3'b111, FMT_U8);
    send_sample(64'h7FC0_0001, 1'b0);
    send_sample(64'h3F80_0000, 1'b0);
    send_sample(64'hC000_0000, 1'b1);
    configure(3'(DIR_FROM_FLOAT), FMT_S32);
    send_sample(64'h3F80_0000, 1'b0);
    send_sample(64'hFF80_0000, 1'b0);
    configure(3'(DIR_FROM_FLOAT), FMT_S24IN32);
    send_sample(64'hBF80_0000, 1'b0);
    configure(3'(DIR_FROM_FLOAT), FMT_F64);
    send_sample(64'hFFA0_0001, 1'b0);
    send_sample(64'h0000_0001, 1'b0);
  endtask

  task automatic test_unknown_format;
    configure(3'(DIR_FROM_FLOAT), FMT_UNKNOWN);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    configure(3'(DIR_TO_FLOAT), FMT_UNKNOWN);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_settings;
    for (int d = 0; d < 2; d++) begin
      for (int fm = 0; fm < 8; fm++) begin
        configure(3'(d), 3'(fm));
        gaps_on    = ((d * 8 + fm) % 5) != 3;
        burst_left = 0;
        repeat (52) send_with_gaps(random_sample(cur_dir, cur_fmt), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_DIRECTION;
    cfg_wdata  = '0;
    cur_dir    = DIR_TO_FLOAT;
    cur_fmt    = FMT_S16;
    fail_count = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_to_float_edges();
    test_from_float_edges();
    test_unknown_format();
    test_random_settings();
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("pcm_float_sample_converter test passed");
    end else begin
      $display("pcm_float_sample_converter test failed");
    end
    $finish;
  end

endmodule
